// File: rtl/prjb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prjb_pkg
// Shared constants, codes and types of the packet reorder jitter buffer.
// ----------------------------------------------------------------------------
package prjb_pkg;

   localparam int QUEUE_DEPTH   = 64;
   localparam int SEQ_BITS      = 32;
   localparam int TAG_BITS      = 8;
   localparam int IDX_BITS      = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
   localparam int STAT_BITS     = 32;
   localparam int GAP_BITS      = 16;
   localparam int NUM_STATS     = 9;
   localparam int STAT_IDX_BITS = 4;
   localparam int CMD_BITS      = 2;
   localparam int STATUS_BITS   = 3;
   localparam int ENTRY_BITS    = SEQ_BITS + TAG_BITS + 1;

   localparam logic [CMD_BITS-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_READ = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_NONE = 2'd3;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FILL  = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_LATE  = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_DUP   = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 3'd4;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 3'd5;
   localparam logic [STATUS_BITS-1:0] STATUS_READ  = 3'd6;

   localparam int STAT_LATE   = 0;
   localparam int STAT_DROP   = 1;
   localparam int STAT_OOO    = 2;
   localparam int STAT_DUP    = 3;
   localparam int STAT_HEAL   = 4;
   localparam int STAT_PUSH   = 5;
   localparam int STAT_POP    = 6;
   localparam int STAT_MAXGAP = 7;
   localparam int STAT_SPAN   = 8;

   typedef struct packed {
      logic [SEQ_BITS-1:0] seq;
      logic [TAG_BITS-1:0] tag;
      logic                fec;
   } entry_type;

   typedef struct packed {
      logic [NUM_STATS-1:0] bump;
      logic                 gap_en;
      logic [GAP_BITS-1:0]  gap;
      logic                 span_en;
      logic [SEQ_BITS-1:0]  span;
   } stat_upd_type;

endpackage
`default_nettype wire

// File: rtl/prjb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prjb_if
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface prjb_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [prjb_pkg::CMD_BITS-1:0]          cmd;
   logic [prjb_pkg::SEQ_BITS-1:0]          seq;
   logic [prjb_pkg::TAG_BITS-1:0]          tag;
   logic                                   fec;
   logic [prjb_pkg::STAT_IDX_BITS-1:0]     stat_index;

   modport source (output valid, cmd, seq, tag, fec, stat_index, input ready);
   modport sink   (input valid, cmd, seq, tag, fec, stat_index, output ready);
endinterface

interface prjb_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [prjb_pkg::STATUS_BITS-1:0]       status;
   logic [prjb_pkg::SEQ_BITS-1:0]          seq_out;
   logic [prjb_pkg::TAG_BITS-1:0]          tag_out;
   logic                                   fill_in;
   logic                                   healed;
   logic                                   silent;
   logic [prjb_pkg::STAT_BITS-1:0]         stat_value;
   logic [prjb_pkg::CNT_BITS-1:0]          queue_count;

   modport source (output valid, status, seq_out, tag_out, fill_in, healed, silent,
                   stat_value, queue_count, input ready);
   modport sink   (input valid, status, seq_out, tag_out, fill_in, healed, silent,
                   stat_value, queue_count, output ready);
endinterface
`default_nettype wire

// File: rtl/prjb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prjb_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module prjb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// File: rtl/prjb_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prjb_stats
// Bank of saturating statistics counters with max-tracking entries.
// ----------------------------------------------------------------------------
module prjb_stats (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire prjb_pkg::stat_upd_type             upd,
   input  wire logic [prjb_pkg::STAT_IDX_BITS-1:0] rd_index,
   output logic      [prjb_pkg::STAT_BITS-1:0]     rd_value
);
   import prjb_pkg::*;

   localparam logic [STAT_BITS-1:0] STAT_MAX = '1;

   logic [STAT_BITS-1:0] cnt_ff [NUM_STATS];
   logic [STAT_BITS-1:0] cnt_in [NUM_STATS];
   logic [SEQ_BITS+STAT_BITS-1:0] span_wide;
   logic [STAT_BITS-1:0] span_sat;
   logic [STAT_BITS-1:0] gap_ext;

   always_comb begin
      span_wide = {{STAT_BITS{1'b0}}, upd.span};
      span_sat  = (span_wide > {{SEQ_BITS{1'b0}}, STAT_MAX}) ? STAT_MAX
                                                             : span_wide[STAT_BITS-1:0];
      gap_ext   = {{(STAT_BITS-GAP_BITS){1'b0}}, upd.gap};
      for (int i = 0; i < NUM_STATS; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (upd.bump[i] && cnt_ff[i] != STAT_MAX) begin
            cnt_in[i] = cnt_ff[i] + 1'b1;
         end
      end
      if (upd.gap_en && gap_ext > cnt_ff[STAT_MAXGAP]) begin
         cnt_in[STAT_MAXGAP] = gap_ext;
      end
      if (upd.span_en && span_sat > cnt_ff[STAT_SPAN]) begin
         cnt_in[STAT_SPAN] = span_sat;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_STATS; i++) begin
         if (reset) begin
            cnt_ff[i] <= '0;
         end else begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_comb begin
      rd_value = '0;
      for (int i = 0; i < NUM_STATS; i++) begin
         if (rd_index == STAT_IDX_BITS'(i)) begin
            rd_value = cnt_ff[i];
         end
      end
   end
endmodule
`default_nettype wire

// File: rtl/packet_reorder_jitter_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// packet_reorder_jitter_buffer
// Reorder buffer keyed by sequence number; entries held in one RAM, scanned
// one slot per cycle for duplicate, free slot and lowest sequence number.
// ----------------------------------------------------------------------------
// push and pop: the scan visits every slot of the entry RAM over its read port,
//   then the drain and finish states; the response is registered in finish
// counter read: response registered in the cycle after the request; unused command: none
// one request at a time; the next is taken once the pending response is accepted
// reset: synchronous, clears valid bits, counters and sequence tracking
// ----------------------------------------------------------------------------
module packet_reorder_jitter_buffer (
   input  wire logic  clock,
   input  wire logic  reset,
   prjb_req_if.sink   req_ch,
   prjb_rsp_if.source rsp_ch
);
   import prjb_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(QUEUE_DEPTH - 1);
   localparam logic [GAP_BITS-1:0] GAP_MAX  = '1;

   logic [1:0] state_ff, state_in;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [IDX_BITS-1:0] scan_idx_ff, scan_idx_in;
   logic pend_ff, pend_in;
   logic [IDX_BITS-1:0] pend_idx_ff, pend_idx_in;

   logic [CMD_BITS-1:0] cmd_ff, cmd_in;
   logic [SEQ_BITS-1:0] seq_ff, seq_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic fec_ff, fec_in;

   logic dup_ff, dup_in;
   logic free_found_ff, free_found_in;
   logic [IDX_BITS-1:0] free_idx_ff, free_idx_in;
   logic head_found_ff, head_found_in;
   logic [IDX_BITS-1:0] head_idx_ff, head_idx_in;
   logic [SEQ_BITS-1:0] head_seq_ff, head_seq_in;
   logic [TAG_BITS-1:0] head_tag_ff, head_tag_in;
   logic head_fec_ff, head_fec_in;

   logic [SEQ_BITS-1:0] last_popped_ff, last_popped_in;
   logic popped_any_ff, popped_any_in;
   logic [SEQ_BITS-1:0] last_pushed_ff, last_pushed_in;
   logic [GAP_BITS-1:0] gap_ff, gap_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [SEQ_BITS-1:0] seq_out_ff, seq_out_in;
   logic [TAG_BITS-1:0] tag_out_ff, tag_out_in;
   logic fill_in_ff, fill_in_in;
   logic healed_ff, healed_in;
   logic silent_ff, silent_in;
   logic [STAT_BITS-1:0] stat_value_ff, stat_value_in;
   logic [CNT_BITS-1:0] queue_count_ff, queue_count_in;

   logic accept;
   logic ram_we;
   entry_type ram_wdata, ram_rdata;
   logic [IDX_BITS-1:0] ram_raddr;
   stat_upd_type stat_upd;
   logic [STAT_BITS-1:0] stat_rd_value;
   logic [SEQ_BITS-1:0] next_seq, fill_seq;
   logic [GAP_BITS-1:0] gap_next;

   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   prjb_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (free_idx_ff),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   prjb_stats u_stats (
      .clock    (clock),
      .reset    (reset),
      .upd      (stat_upd),
      .rd_index (req_ch.stat_index),
      .rd_value (stat_rd_value)
   );

   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      count_in       = count_ff;
      scan_idx_in    = scan_idx_ff;
      pend_in        = 1'b0;
      pend_idx_in    = scan_idx_ff;
      cmd_in         = cmd_ff;
      seq_in         = seq_ff;
      tag_in         = tag_ff;
      fec_in         = fec_ff;
      dup_in         = dup_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      head_found_in  = head_found_ff;
      head_idx_in    = head_idx_ff;
      head_seq_in    = head_seq_ff;
      head_tag_in    = head_tag_ff;
      head_fec_in    = head_fec_ff;
      last_popped_in = last_popped_ff;
      popped_any_in  = popped_any_ff;
      last_pushed_in = last_pushed_ff;
      gap_in         = gap_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      status_in      = status_ff;
      seq_out_in     = seq_out_ff;
      tag_out_in     = tag_out_ff;
      fill_in_in     = fill_in_ff;
      healed_in      = healed_ff;
      silent_in      = silent_ff;
      stat_value_in  = stat_value_ff;
      queue_count_in = queue_count_ff;
      ram_we         = 1'b0;
      ram_raddr      = scan_idx_ff;
      ram_wdata      = '{seq: seq_ff, tag: tag_ff, fec: fec_ff};
      stat_upd       = '0;
      next_seq       = last_popped_ff + 1'b1;
      fill_seq       = next_seq;
      gap_next       = (gap_ff == GAP_MAX) ? gap_ff : gap_ff + 1'b1;

      // fold in the slot read last cycle
      if (pend_ff) begin
         if (valid_ff[pend_idx_ff]) begin
            if (ram_rdata.seq == seq_ff) begin
               dup_in = 1'b1;
            end
            if (!head_found_ff || ram_rdata.seq < head_seq_ff) begin
               head_found_in = 1'b1;
               head_idx_in   = pend_idx_ff;
               head_seq_in   = ram_rdata.seq;
               head_tag_in   = ram_rdata.tag;
               head_fec_in   = ram_rdata.fec;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = pend_idx_ff;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in        = req_ch.cmd;
               seq_in        = req_ch.seq;
               tag_in        = req_ch.tag;
               fec_in        = req_ch.fec;
               dup_in        = 1'b0;
               free_found_in = 1'b0;
               head_found_in = 1'b0;
               scan_idx_in   = '0;
               if (req_ch.cmd == CMD_PUSH || req_ch.cmd == CMD_POP) begin
                  state_in = S_SCAN;
               end else if (req_ch.cmd == CMD_READ) begin
                  rsp_valid_in   = 1'b1;
                  status_in      = STATUS_READ;
                  seq_out_in     = '0;
                  tag_out_in     = '0;
                  fill_in_in     = 1'b0;
                  healed_in      = 1'b0;
                  silent_in      = 1'b0;
                  stat_value_in  = stat_rd_value;
                  queue_count_in = count_ff;
               end
            end
         end
         S_SCAN: begin
            pend_in     = 1'b1;
            pend_idx_in = scan_idx_ff;
            if (scan_idx_ff == LAST_IDX) begin
               scan_idx_in = '0;
               state_in    = S_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            seq_out_in    = '0;
            tag_out_in    = '0;
            fill_in_in    = 1'b0;
            healed_in     = 1'b0;
            silent_in     = 1'b0;
            stat_value_in = '0;
            if (cmd_ff == CMD_PUSH) begin
               priority if (popped_any_ff && seq_ff <= last_popped_ff) begin
                  stat_upd.bump[STAT_LATE] = 1'b1;
                  status_in = STATUS_LATE;
               end else if (dup_ff) begin
                  stat_upd.bump[STAT_DUP] = 1'b1;
                  status_in = STATUS_DUP;
               end else if (!free_found_ff) begin
                  status_in = STATUS_FULL;
               end else begin
                  ram_we                = 1'b1;
                  valid_in[free_idx_ff] = 1'b1;
                  count_in              = count_ff + 1'b1;
                  stat_upd.bump[STAT_PUSH] = 1'b1;
                  if (seq_ff < last_pushed_ff) begin
                     stat_upd.bump[STAT_OOO] = 1'b1;
                     stat_upd.span_en        = 1'b1;
                     stat_upd.span           = last_pushed_ff - seq_ff;
                  end
                  last_pushed_in = seq_ff;
                  status_in      = STATUS_OK;
               end
            end else if (!head_found_ff) begin
               status_in = STATUS_EMPTY;
            end else begin
               tag_out_in = head_tag_ff;
               if (!popped_any_ff || next_seq == head_seq_ff) begin
                  valid_in[head_idx_ff] = 1'b0;
                  count_in       = count_ff - 1'b1;
                  last_popped_in = head_seq_ff;
                  popped_any_in  = 1'b1;
                  gap_in         = '0;
                  stat_upd.bump[STAT_POP] = 1'b1;
                  status_in      = STATUS_OK;
                  seq_out_in     = head_seq_ff;
               end else begin
                  if (gap_ff == '0) begin
                     fill_seq = next_seq;
                     if (head_fec_ff) begin
                        healed_in = 1'b1;
                        stat_upd.bump[STAT_HEAL] = 1'b1;
                     end else begin
                        stat_upd.bump[STAT_DROP] = 1'b1;
                     end
                  end else begin
                     fill_seq  = head_seq_ff - 1'b1;
                     silent_in = 1'b1;
                     stat_upd.bump[STAT_DROP] = 1'b1;
                  end
                  last_popped_in  = fill_seq;
                  gap_in          = gap_next;
                  stat_upd.gap_en = 1'b1;
                  stat_upd.gap    = gap_next;
                  status_in       = STATUS_FILL;
                  seq_out_in      = fill_seq;
                  fill_in_in      = 1'b1;
               end
            end
            queue_count_in = count_in;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         valid_ff       <= '0;
         count_ff       <= '0;
         scan_idx_ff    <= '0;
         pend_ff        <= 1'b0;
         last_popped_ff <= '0;
         popped_any_ff  <= 1'b0;
         last_pushed_ff <= '0;
         gap_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         count_ff       <= count_in;
         scan_idx_ff    <= scan_idx_in;
         pend_ff        <= pend_in;
         last_popped_ff <= last_popped_in;
         popped_any_ff  <= popped_any_in;
         last_pushed_ff <= last_pushed_in;
         gap_ff         <= gap_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff    <= pend_idx_in;
      cmd_ff         <= cmd_in;
      seq_ff         <= seq_in;
      tag_ff         <= tag_in;
      fec_ff         <= fec_in;
      dup_ff         <= dup_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      head_found_ff  <= head_found_in;
      head_idx_ff    <= head_idx_in;
      head_seq_ff    <= head_seq_in;
      head_tag_ff    <= head_tag_in;
      head_fec_ff    <= head_fec_in;
      status_ff      <= status_in;
      seq_out_ff     <= seq_out_in;
      tag_out_ff     <= tag_out_in;
      fill_in_ff     <= fill_in_in;
      healed_ff      <= healed_in;
      silent_ff      <= silent_in;
      stat_value_ff  <= stat_value_in;
      queue_count_ff <= queue_count_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.seq_out     = seq_out_ff;
   assign rsp_ch.tag_out     = tag_out_ff;
   assign rsp_ch.fill_in     = fill_in_ff;
   assign rsp_ch.healed      = healed_ff;
   assign rsp_ch.silent      = silent_ff;
   assign rsp_ch.stat_value  = stat_value_ff;
   assign rsp_ch.queue_count = queue_count_ff;
endmodule
`default_nettype wire

// File: bench/packet_reorder_jitter_buffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_reorder_jitter_buffer_tb
// Drives push, pop, counter-read and unused requests through the reorder buffer with
// random idling on both channels, predicts every response from a local model
// of the slot store, sequence tracking and statistics, and compares fields.
// ----------------------------------------------------------------------------
module packet_reorder_jitter_buffer_tb;
   import prjb_pkg::*;

   typedef struct {
      logic [CMD_BITS-1:0]      cmd;
      logic [SEQ_BITS-1:0]      seq;
      logic [TAG_BITS-1:0]      tag;
      logic                     fec;
      logic [STAT_IDX_BITS-1:0] stat_index;
   } request_type;

   typedef struct {
      logic [STATUS_BITS-1:0] status;
      logic [SEQ_BITS-1:0]    seq_out;
      logic [TAG_BITS-1:0]    tag_out;
      logic                   fill_in;
      logic                   healed;
      logic                   silent;
      logic [STAT_BITS-1:0]   stat_value;
      logic [CNT_BITS-1:0]    queue_count;
   } response_type;

   logic clock;
   logic reset;

   prjb_req_if req_ch ();
   prjb_rsp_if rsp_ch ();

   packet_reorder_jitter_buffer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // buffer model state
   logic [SEQ_BITS-1:0] slot_seq   [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] slot_tag   [QUEUE_DEPTH];
   logic                slot_fec   [QUEUE_DEPTH];
   logic                slot_valid [QUEUE_DEPTH];
   logic [SEQ_BITS-1:0] played_seq;
   logic                played_any;
   logic [SEQ_BITS-1:0] newest_seq;
   logic [GAP_BITS-1:0] gap_run;
   logic [STAT_BITS-1:0] counters [NUM_STATS];

   request_type  pending_requests[$];
   response_type expected_responses[$];
   int        errors = 0;
   int        n_push = 0, n_pop = 0, n_fill = 0, n_read = 0;
   bit        calm = 0;

   function automatic void bump_counter(int i);
      if (counters[i] != '1) counters[i] = counters[i] + 1;
   endfunction

   function automatic void raise_counter(int i, logic [STAT_BITS-1:0] v);
      if (v > counters[i]) counters[i] = v;
   endfunction

   function automatic void predict_buffer(request_type r);
      response_type e;
      int free_slot, head;
      bit dup;
      int held;
      logic [SEQ_BITS-1:0] fs;
      free_slot = -1;
      head = -1;
      dup = 0;
      held = 0;
      e = '{default: '0};
      if (r.cmd == CMD_NONE) return;
      if (r.cmd == CMD_PUSH) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (slot_valid[i]) begin
               if (slot_seq[i] == r.seq) dup = 1;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (played_any && r.seq <= played_seq) begin
            bump_counter(STAT_LATE);
            e.status = STATUS_LATE;
         end else if (dup) begin
            bump_counter(STAT_DUP);
            e.status = STATUS_DUP;
         end else if (free_slot < 0) begin
            e.status = STATUS_FULL;
         end else begin
            slot_seq[free_slot]   = r.seq;
            slot_tag[free_slot]   = r.tag;
            slot_fec[free_slot]   = r.fec;
            slot_valid[free_slot] = 1;
            bump_counter(STAT_PUSH);
            if (r.seq < newest_seq) begin
               bump_counter(STAT_OOO);
               raise_counter(STAT_SPAN, newest_seq - r.seq);
            end
            newest_seq = r.seq;
            e.status = STATUS_OK;
         end
      end else if (r.cmd == CMD_POP) begin
         for (int i = 0; i < QUEUE_DEPTH; i++)
            if (slot_valid[i] && (head < 0 || slot_seq[i] < slot_seq[head])) head = i;
         if (head < 0) begin
            e.status = STATUS_EMPTY;
         end else begin
            e.tag_out = slot_tag[head];
            if (!played_any || played_seq + 1'b1 == slot_seq[head]) begin
               slot_valid[head] = 0;
               played_seq = slot_seq[head];
               played_any = 1;
               gap_run = 0;
               bump_counter(STAT_POP);
               e.status = STATUS_OK;
               e.seq_out = slot_seq[head];
            end else begin
               if (gap_run == 0) begin
                  fs = played_seq + 1'b1;
                  if (slot_fec[head]) begin
                     e.healed = 1;
                     bump_counter(STAT_HEAL);
                  end else begin
                     bump_counter(STAT_DROP);
                  end
               end else begin
                  fs = slot_seq[head] - 1'b1;
                  e.silent = 1;
                  bump_counter(STAT_DROP);
               end
               played_seq = fs;
               if (gap_run != '1) gap_run = gap_run + 1'b1;
               raise_counter(STAT_MAXGAP, STAT_BITS'(gap_run));
               e.status = STATUS_FILL;
               e.seq_out = fs;
               e.fill_in = 1;
            end
         end
      end else begin
         e.status = STATUS_READ;
         e.stat_value = (r.stat_index < NUM_STATS) ? counters[r.stat_index] : '0;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) if (slot_valid[i]) held++;
      e.queue_count = CNT_BITS'(held);
      expected_responses.push_back(e);
   endfunction

   function automatic void add_request(logic [CMD_BITS-1:0] c, logic [SEQ_BITS-1:0] s,
                                       logic [TAG_BITS-1:0] t, logic f,
                                       logic [STAT_IDX_BITS-1:0] x);
      request_type r;
      r.cmd = c; r.seq = s; r.tag = t; r.fec = f; r.stat_index = x;
      pending_requests.push_back(r);
   endfunction

   function automatic void add_random_noise();
      add_request(CMD_BITS'($urandom_range(0, 3)), $urandom, TAG_BITS'($urandom),
                  1'($urandom), STAT_IDX_BITS'($urandom));
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) predict_buffer(pending_requests.pop_front());
         if (pending_requests.size() > 0 &&
             (calm || $urandom_range(0, 99) >= 33)) begin
            req_ch.valid      <= 1;
            req_ch.cmd        <= pending_requests[0].cmd;
            req_ch.seq        <= pending_requests[0].seq;
            req_ch.tag        <= pending_requests[0].tag;
            req_ch.fec        <= pending_requests[0].fec;
            req_ch.stat_index <= pending_requests[0].stat_index;
         end else begin
            req_ch.valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      response_type e;
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_responses.size() == 0) begin
               $display("%0t: unexpected response status %0d", $time, rsp_ch.status);
               errors++;
            end else begin
               e = expected_responses.pop_front();
               if (e.status == STATUS_FILL) n_fill++;
               if (rsp_ch.status !== e.status || rsp_ch.seq_out !== e.seq_out ||
                   rsp_ch.tag_out !== e.tag_out || rsp_ch.fill_in !== e.fill_in ||
                   rsp_ch.healed !== e.healed || rsp_ch.silent !== e.silent ||
                   rsp_ch.stat_value !== e.stat_value ||
                   rsp_ch.queue_count !== e.queue_count) begin
                  $display("%0t: mismatch expected st=%0d seq=%0d tag=%0d f=%b h=%b s=%b v=%0d q=%0d",
                           $time, e.status, e.seq_out, e.tag_out, e.fill_in, e.healed,
                           e.silent, e.stat_value, e.queue_count);
                  $display("%0t:          actual st=%0d seq=%0d tag=%0d f=%b h=%b s=%b v=%0d q=%0d",
                           $time, rsp_ch.status, rsp_ch.seq_out, rsp_ch.tag_out,
                           rsp_ch.fill_in, rsp_ch.healed, rsp_ch.silent,
                           rsp_ch.stat_value, rsp_ch.queue_count);
                  errors++;
               end
            end
         end
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
      end
   end

   initial begin
      logic [SEQ_BITS-1:0] base;
      int burst;
      int calm_from, calm_to, total;
      req_ch.valid = 0; req_ch.cmd = CMD_NONE; req_ch.seq = 0; req_ch.tag = 0;
      req_ch.fec = 0; req_ch.stat_index = 0; rsp_ch.ready = 0;
      for (int i = 0; i < QUEUE_DEPTH; i++) slot_valid[i] = 0;
      for (int i = 0; i < NUM_STATS; i++) counters[i] = 0;
      played_seq = 0; played_any = 0; newest_seq = 0; gap_run = 0;
      calm_from = 0; calm_to = 0;
      reset = 1;
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed: empty pop, push before first pop, ordering, gaps, late, dup
      add_request(CMD_POP, 0, 0, 0, 0);
      add_request(CMD_PUSH, 32'hFFFF_FFF0, 8'hFF, 1, 0);
      add_request(CMD_PUSH, 10, 8'h01, 0, 0);
      add_request(CMD_PUSH, 10, 8'h02, 0, 0);
      add_request(CMD_PUSH, 13, 8'hA5, 1, 0);
      add_request(CMD_PUSH, 0, 8'h00, 0, 0);
      add_request(CMD_POP, 0, 0, 0, 0);
      add_request(CMD_POP, 0, 0, 0, 0);
      add_request(CMD_POP, 0, 0, 0, 0);
      add_request(CMD_POP, 0, 0, 0, 0);
      add_request(CMD_POP, 0, 0, 0, 0);
      add_request(CMD_PUSH, 12, 8'h33, 0, 0);
      add_request(CMD_PUSH, 11, 8'h34, 0, 0);
      add_request(CMD_PUSH, 16, 8'h35, 0, 0);
      add_request(CMD_POP, 0, 0, 0, 0);
      add_request(CMD_POP, 0, 0, 0, 0);
      add_request(CMD_NONE, 5, 5, 1, 5);
      for (int i = 0; i <= 15; i += 1)
         if (i < 9 || i == 15) add_request(CMD_READ, 0, 0, 0, STAT_IDX_BITS'(i));

      // random: runs of pushes with local disorder, pops, reads and noise
      base = 32'd100;
      for (int n = 0; n < 130; n++) begin
         burst = $urandom_range(1, 6);
         for (int k = 0; k < burst; k++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: add_request(CMD_PUSH, base + $urandom_range(0, 12),
                                        TAG_BITS'($urandom), 1'($urandom), 0);
               4, 5, 6: add_request(CMD_POP, 0, 0, 0, 0);
               7: add_request(CMD_READ, 0, 0, 0, STAT_IDX_BITS'($urandom_range(0, 15)));
               8: add_request(CMD_PUSH, base - $urandom_range(0, 40), TAG_BITS'($urandom),
                              1'($urandom), 0);
               default: add_random_noise();
            endcase
         end
         base = base + $urandom_range(0, 4);
         if (n == 60) begin
            // fill the buffer to overflow
            for (int k = 0; k < QUEUE_DEPTH + 3; k++)
               add_request(CMD_PUSH, 32'h8000_0000 + k * 2, TAG_BITS'($urandom),
                           1'($urandom), 0);
            for (int k = 0; k < 8; k++) add_request(CMD_POP, 0, 0, 0, 0);
         end
         if (n == 90) calm_from = pending_requests.size();
         if (n == 105) calm_to = pending_requests.size();
      end
      for (int i = 0; i < NUM_STATS; i++) add_request(CMD_READ, 0, 0, 0, STAT_IDX_BITS'(i));
      n_push = 0;
      foreach (pending_requests[i]) begin
         if (pending_requests[i].cmd == CMD_PUSH) n_push++;
         if (pending_requests[i].cmd == CMD_POP) n_pop++;
         if (pending_requests[i].cmd == CMD_READ) n_read++;
      end
      total = pending_requests.size();

      // no idling on either side while this stretch of requests goes through
      wait (pending_requests.size() <= total - calm_from);
      calm = 1;
      wait (pending_requests.size() <= total - calm_to);
      calm = 0;

      wait (pending_requests.size() == 0);
      wait (expected_responses.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d pushes, %0d pops (%0d fill-ins), %0d counter reads",
               n_push, n_pop, n_fill, n_read);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
